// ----- rtl/core/sapb_pkg.sv -----
// shared types, register indexes and reset values for the pixel blend
package sapb_pkg;

    localparam int unsigned PIX_W   = 32;
    localparam int unsigned ALPHA_W = 8;
    localparam int unsigned KEY16_W = 16;
    localparam int unsigned KEY24_W = 24;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 24;

    // register indexes on the configuration channel
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ALPHA     = 2'd0,
        REG_WIDE_MODE = 2'd1,
        REG_KEY_16    = 2'd2,
        REG_KEY_24    = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [ALPHA_W-1:0] alpha;
        logic               wide_mode;
        logic [KEY16_W-1:0] key_16;
        logic [KEY24_W-1:0] key_24;
    } t_cfg;

    localparam logic [ALPHA_W-1:0] ALPHA_RST = 8'hFF;
    localparam logic               WIDE_RST  = 1'b1;
    localparam logic [KEY16_W-1:0] KEY16_RST = 16'hF81F;
    localparam logic [KEY24_W-1:0] KEY24_RST = 24'hFF00FF;

endpackage

// ----- rtl/core/sapb_blend.sv -----
// combinational blend of one source and one destination pixel
module sapb_blend (
    input  sapb_pkg::t_cfg                 i_cfg,
    input  logic [sapb_pkg::PIX_W-1:0]     i_src,
    input  logic [sapb_pkg::PIX_W-1:0]     i_dst,
    output logic [sapb_pkg::PIX_W-1:0]     o_pixel,
    output logic                           o_written
);
    import sapb_pkg::*;

    // rgb565 scale, 0..32
    logic [5:0]  a5;
    logic [8:0]  a_sum;
    logic [4:0]  s_ch [3];
    logic [4:0]  d_ch [3];
    logic [4:0]  sat_ch [3];
    logic [10:0] p16  [3];
    logic [5:0]  t16  [3];
    logic [15:0] p32  [4];
    logic [8:0]  t32  [4];
    logic [7:0]  b32  [4];
    logic [15:0] px16;
    logic [31:0] px32;
    logic        key_hit;

    assign a_sum = {1'b0, i_cfg.alpha} + 9'd7;
    assign a5    = a_sum[8:3];

    // channel order: blue, green (top 5 bits), red
    assign s_ch[0] = i_src[4:0];
    assign s_ch[1] = i_src[10:6];
    assign s_ch[2] = i_src[15:11];
    assign d_ch[0] = i_dst[4:0];
    assign d_ch[1] = i_dst[10:6];
    assign d_ch[2] = i_dst[15:11];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            p16[i]    = {6'd0, s_ch[i]} * {5'd0, a5};
            t16[i]    = p16[i][10:5] + {1'b0, d_ch[i]};
            sat_ch[i] = (t16[i] > 6'd31) ? 5'd31 : t16[i][4:0];
        end
        for (int j = 0; j < 4; j++) begin
            p32[j] = {8'd0, i_src[8*j +: 8]} * {8'd0, i_cfg.alpha};
            t32[j] = {1'b0, p32[j][15:8]} + {1'b0, i_dst[8*j +: 8]};
            b32[j] = t32[j][8] ? 8'hFF : t32[j][7:0];
        end
    end

    assign px16 = {sat_ch[2], sat_ch[1], 1'b0, sat_ch[0]};
    assign px32 = {b32[3], b32[2], b32[1], b32[0]};

    assign key_hit = i_cfg.wide_mode ? (i_src[23:0] == i_cfg.key_24)
                                     : (i_src[15:0] == i_cfg.key_16);

    always_comb begin
        if (i_cfg.wide_mode) begin
            o_pixel = key_hit ? i_dst : px32;
        end else begin
            o_pixel = {16'd0, key_hit ? i_dst[15:0] : px16};
        end
        o_written = ~key_hit;
    end

endmodule

// ----- rtl/core/saturating_additive_pixel_blend.sv -----
// top level: saturating additive pixel blend, rgb565 or 32-bit, with color key
//
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   tdata: src_pixel[31:0], dst_pixel[63:32]
//  m_axis    out  m_axis_tvalid/m_axis_tready   tdata: out_pixel, tuser: written
//  cfg       in   i_cfg_valid/o_cfg_ready       i_cfg_index, i_cfg_data
//
//  data path: input register, then blend logic into the result register
//  one pixel per cycle unless m_axis stalls; four 8x8 byte multipliers set stage depth
//  a stalled m_axis holds the result while one more request waits in the input register
//  synchronous active-low reset clears the valid flags and loads the register defaults
//  config writes are always taken and should only come while the stream is idle
module saturating_additive_pixel_blend (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // slave stream: [31:0] src_pixel, [63:32] dst_pixel
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [2*sapb_pkg::PIX_W-1:0]       s_axis_tdata,
    // master stream: [31:0] out_pixel
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [sapb_pkg::PIX_W-1:0]         m_axis_tdata,
    // [0] written
    output logic [0:0]                         m_axis_tuser,
    // config write channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [sapb_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [sapb_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import sapb_pkg::*;

    // configuration registers
    t_cfg r_cfg;

    // input register stage
    logic             r_s1_valid;
    logic [PIX_W-1:0] r_s1_src;
    logic [PIX_W-1:0] r_s1_dst;

    // result register stage
    logic             r_out_valid;
    logic [PIX_W-1:0] r_out_pixel;
    logic             r_out_written;

    logic             n_out_valid;
    logic [PIX_W-1:0] n_out_pixel;
    logic             n_out_written;

    logic s1_advance;
    logic s_accept;

    assign o_cfg_ready = 1'b1;

    // write one config register per request, extra data bits ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.alpha     <= ALPHA_RST;
            r_cfg.wide_mode <= WIDE_RST;
            r_cfg.key_16    <= KEY16_RST;
            r_cfg.key_24    <= KEY24_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_ALPHA:     r_cfg.alpha     <= i_cfg_data[ALPHA_W-1:0];
                REG_WIDE_MODE: r_cfg.wide_mode <= i_cfg_data[0];
                REG_KEY_16:    r_cfg.key_16    <= i_cfg_data[KEY16_W-1:0];
                REG_KEY_24:    r_cfg.key_24    <= i_cfg_data[KEY24_W-1:0];
                default: ;
            endcase
        end
    end

    // stage 1 moves forward when the result register is empty or being drained
    assign s1_advance    = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || s1_advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1_src <= s_axis_tdata[PIX_W-1:0];
            r_s1_dst <= s_axis_tdata[2*PIX_W-1:PIX_W];
        end
    end

    // blend datapath between the two register stages
    sapb_blend u_blend (
        .i_cfg     (r_cfg),
        .i_src     (r_s1_src),
        .i_dst     (r_s1_dst),
        .o_pixel   (n_out_pixel),
        .o_written (n_out_written)
    );

    // result register keeps its contents while the sink stalls
    always_comb begin
        n_out_valid = r_out_valid;
        if (s1_advance) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_advance) begin
            r_out_pixel   <= n_out_pixel;
            r_out_written <= n_out_written;
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out_pixel;
    assign m_axis_tuser[0] = r_out_written;

    // an accepted request always lands in the input register
    a_accept_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> r_s1_valid)
        else $error("accepted request not held in input stage");

    // a request moving out of stage 1 shows up as a result
    a_advance_gives_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_advance |=> m_axis_tvalid)
        else $error("advanced request did not reach result register");

    // with both stages full and the sink stalled, nothing is dropped
    a_full_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && !m_axis_tready) |=> (r_s1_valid && r_out_valid))
        else $error("request lost under stall");

endmodule
